/* hdl/ihrc_pkg.sv */
// shared types and constants for the ipv4 header receive check
package ihrc_pkg;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_VERSION  = 3'd1,
		VERDICT_HEADLEN  = 3'd2,
		VERDICT_TTL      = 3'd3,
		VERDICT_DEST     = 3'd4,
		VERDICT_CHECKSUM = 3'd5
	} verdict_t;

	localparam logic [3:0]  IP_VERSION     = 4'd4;
	localparam logic [3:0]  MIN_IHL        = 4'd5;
	localparam logic [5:0]  IDX_VER_IHL    = 6'd0;
	localparam logic [5:0]  IDX_TTL        = 6'd8;
	localparam logic [5:0]  IDX_DEST_FIRST = 6'd16;
	localparam logic [5:0]  IDX_DEST_LAST  = 6'd19;
	localparam logic [5:0]  IDX_MAX        = 6'd63;
	localparam logic [31:0] BROADCAST_ADDR = 32'hffff_ffff;
	localparam logic [15:0] SUM_GOOD       = 16'hffff;

	typedef struct packed {
		logic       step;
		logic [7:0] data_byte;
		logic       last_byte;
	} hdr_req_t;

endpackage

/* hdl/ihrc_hdr_track.sv */
// per-packet header tracking state and verdict logic
module ihrc_hdr_track
	import ihrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  hdr_req_t    req,
	input  logic [31:0] local_address,
	output verdict_t    verdict_next
);

	logic [5:0]  byte_index_q, byte_index_n;
	logic [3:0]  header_words_q, header_words_n;
	logic        version_bad_q, version_bad_n;
	logic        ttl_zero_q, ttl_zero_n;
	logic [31:0] dest_shift_q, dest_shift_n;
	logic [7:0]  high_byte_hold_q, high_byte_hold_n;
	logic [15:0] ones_sum_q, ones_sum_n;
	logic        header_done_q, header_done_n;
	logic [16:0] sum_wide;
	logic [5:0]  end_index;

	always_comb begin
		byte_index_n     = byte_index_q;
		header_words_n   = header_words_q;
		version_bad_n    = version_bad_q;
		ttl_zero_n       = ttl_zero_q;
		dest_shift_n     = dest_shift_q;
		high_byte_hold_n = high_byte_hold_q;
		ones_sum_n       = ones_sum_q;
		header_done_n    = header_done_q;
		sum_wide         = {1'b0, ones_sum_q} + {1'b0, high_byte_hold_q, req.data_byte};
		end_index        = 6'd0;
		if (!header_done_q) begin
			if (byte_index_q == IDX_VER_IHL) begin
				header_words_n = req.data_byte[3:0];
				version_bad_n  = req.data_byte[7:4] != IP_VERSION;
			end
			if (byte_index_q == IDX_TTL)
				ttl_zero_n = req.data_byte == 8'd0;
			if (byte_index_q >= IDX_DEST_FIRST && byte_index_q <= IDX_DEST_LAST)
				dest_shift_n = {dest_shift_q[23:0], req.data_byte};
			if (!byte_index_q[0])
				high_byte_hold_n = req.data_byte;
			else
				ones_sum_n = sum_wide[15:0] + {15'd0, sum_wide[16]};
			end_index = {header_words_n, 2'b00} - 6'd1;
			if (header_words_n >= MIN_IHL && byte_index_q == end_index)
				header_done_n = 1'b1;
			if (byte_index_q < IDX_MAX)
				byte_index_n = byte_index_q + 6'd1;
		end
	end

	always_comb begin
		if (version_bad_n)
			verdict_next = VERDICT_VERSION;
		else if (header_words_n < MIN_IHL || !header_done_n)
			verdict_next = VERDICT_HEADLEN;
		else if (ttl_zero_n)
			verdict_next = VERDICT_TTL;
		else if (dest_shift_n != local_address && dest_shift_n != BROADCAST_ADDR)
			verdict_next = VERDICT_DEST;
		else if (ones_sum_n != SUM_GOOD)
			verdict_next = VERDICT_CHECKSUM;
		else
			verdict_next = VERDICT_ACCEPT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q     <= '0;
			header_words_q   <= '0;
			version_bad_q    <= 1'b0;
			ttl_zero_q       <= 1'b0;
			dest_shift_q     <= '0;
			high_byte_hold_q <= '0;
			ones_sum_q       <= '0;
			header_done_q    <= 1'b0;
		end else if (req.step) begin
			if (req.last_byte) begin
				byte_index_q     <= '0;
				header_words_q   <= '0;
				version_bad_q    <= 1'b0;
				ttl_zero_q       <= 1'b0;
				dest_shift_q     <= '0;
				high_byte_hold_q <= '0;
				ones_sum_q       <= '0;
				header_done_q    <= 1'b0;
			end else begin
				byte_index_q     <= byte_index_n;
				header_words_q   <= header_words_n;
				version_bad_q    <= version_bad_n;
				ttl_zero_q       <= ttl_zero_n;
				dest_shift_q     <= dest_shift_n;
				high_byte_hold_q <= high_byte_hold_n;
				ones_sum_q       <= ones_sum_n;
				header_done_q    <= header_done_n;
			end
		end
	end

endmodule

/* hdl/ipv4_header_receive_check.sv */
// top level of the ipv4 header receive check
// path: an accepted last byte sits in the input register, then sets out_valid in the result register as it advances
// throughput: one byte per cycle, set by the input and result registers
// a request stalls only when a verdict waits in the result register
// reset: arst_n clears packet state, both valid flags and local_address
module ipv4_header_receive_check
	import ihrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data
);

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        last_byte_s1;
	logic        advance_s1;
	logic        out_valid_q;
	verdict_t    verdict_q;
	verdict_t    verdict_next;
	logic [31:0] local_address_q;
	hdr_req_t    track_req;

	// a non-last byte makes no result and never waits
	assign advance_s1 = valid_s1 && !(last_byte_s1 && out_valid_q && !out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	assign track_req.step      = advance_s1;
	assign track_req.data_byte = data_byte_s1;
	assign track_req.last_byte = last_byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			local_address_q <= '0;
		else if (cfg_write_en)
			local_address_q <= cfg_write_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	ihrc_hdr_track u_hdr_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (track_req),
		.local_address (local_address_q),
		.verdict_next  (verdict_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance_s1 && last_byte_s1)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_byte_s1)
			verdict_q <= verdict_next;
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule
